// File: hw/rtl/plti_pkg.sv
// Shared constants and types for the pixel log transform and inverse block.
// No dependencies; every other file in hw/rtl except plti_norm_cell uses this package.
package plti_pkg;

  localparam int DATA_WIDTH_DEF = 32;
  localparam int FRAC_BITS_DEF  = 16;

  // Internal fraction bits of the log and exp datapaths.
  localparam int IP = 30;

  // Long division: integer quotient bits, then IP fraction bits.
  localparam int INT_STEPS = 6;
  localparam int DIV_STEPS = INT_STEPS + IP;

  localparam int EXP_TERMS = 16;

  localparam logic [28:0] LOG10_2_I = 29'd323228497;
  localparam logic [31:0] LOG2_10_I = 32'd3566893132;
  localparam logic [29:0] LN2_I     = 30'd744261118;

  typedef enum logic [1:0] {
    ST_OK       = 2'd0,
    ST_BAD_NORM = 2'd1,
    ST_SAT      = 2'd2
  } status_t;

  typedef enum logic {
    CFG_INVERSE_MODE = 1'b0,
    CFG_NORM_FACTOR  = 1'b1
  } cfg_idx_t;

endpackage

// File: hw/rtl/plti_norm_cell.sv
// One stage of the leading-zero normalizer: shift left by SH when the top SH bits are zero.
// Depends on nothing but its parameters.
module plti_norm_cell #(
  parameter int DW = 32,
  parameter int CW = 5,
  parameter int SH = 16
) (
  input  logic          clk,
  input  logic          en,
  input  logic [DW-1:0] w_i,
  input  logic [CW-1:0] cnt_i,
  output logic [DW-1:0] w_o,
  output logic [CW-1:0] cnt_o
);

  logic [DW-1:0] w_r, w_nxt;
  logic [CW-1:0] cnt_r, cnt_nxt;

  always_comb begin
    if (w_i[DW-1 -: SH] == '0) begin
      w_nxt   = w_i << SH;
      cnt_nxt = cnt_i + CW'(SH);
    end else begin
      w_nxt   = w_i;
      cnt_nxt = cnt_i;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      w_r   <= w_nxt;
      cnt_r <= cnt_nxt;
    end
  end

  assign w_o   = w_r;
  assign cnt_o = cnt_r;

endmodule

// File: hw/rtl/plti_sqr_cell.sv
// One squaring round of the log2 fraction extraction: square the mantissa, renormalize,
// and shift in one result bit. Uses plti_pkg::IP.
module plti_sqr_cell (
  input  logic                    clk,
  input  logic                    en,
  input  logic [plti_pkg::IP:0]   m_i,
  input  logic [plti_pkg::IP-1:0] fr_i,
  output logic [plti_pkg::IP:0]   m_o,
  output logic [plti_pkg::IP-1:0] fr_o
);

  localparam int IP = plti_pkg::IP;

  logic [2*IP+1:0] sq;
  logic [IP+1:0]   m_sh;
  logic [IP:0]     m_r, m_nxt;
  logic [IP-1:0]   fr_r, fr_nxt;

  always_comb begin
    sq   = m_i * m_i;
    m_sh = sq[2*IP+1:IP];
    // mantissa reached [2,4): halve it and record a one
    if (m_sh[IP+1]) begin
      m_nxt = m_sh[IP+1:1];
    end else begin
      m_nxt = m_sh[IP:0];
    end
    fr_nxt = {fr_i[IP-2:0], m_sh[IP+1]};
  end

  always_ff @(posedge clk) begin
    if (en) begin
      m_r  <= m_nxt;
      fr_r <= fr_nxt;
    end
  end

  assign m_o  = m_r;
  assign fr_o = fr_r;

endmodule

// File: hw/rtl/plti_div_cell.sv
// One restoring step of the |x| / norm long division; integer steps compare against a
// shifted divisor, fraction steps shift the remainder. Uses plti_pkg::DIV_STEPS.
module plti_div_cell #(
  parameter int RW       = 39,
  parameter bit SHIFT_IN = 1'b0,
  parameter int DSH      = 0
) (
  input  logic                           clk,
  input  logic                           en,
  input  logic [31:0]                    norm_i,
  input  logic [RW-1:0]                  r_i,
  input  logic [plti_pkg::DIV_STEPS-1:0] q_i,
  output logic [RW-1:0]                  r_o,
  output logic [plti_pkg::DIV_STEPS-1:0] q_o
);

  localparam int QW = plti_pkg::DIV_STEPS;

  logic [RW-1:0] r_s, d, r_r, r_nxt;
  logic [QW-1:0] q_r, q_nxt;
  logic          ge;

  always_comb begin
    r_s   = SHIFT_IN ? {r_i[RW-2:0], 1'b0} : r_i;
    d     = RW'(norm_i) << DSH;
    ge    = (r_s >= d);
    r_nxt = ge ? (r_s - d) : r_s;
    q_nxt = {q_i[QW-2:0], ge};
  end

  always_ff @(posedge clk) begin
    if (en) begin
      r_r <= r_nxt;
      q_r <= q_nxt;
    end
  end

  assign r_o = r_r;
  assign q_o = q_r;

endmodule

// File: hw/rtl/plti_term_cell.sv
// One term of the exp series over three stages: term * g, divide by K through a
// reciprocal with one correction, then accumulate. Uses plti_pkg::IP.
module plti_term_cell #(
  parameter int K = 1
) (
  input  logic                    clk,
  input  logic                    en,
  input  logic [plti_pkg::IP-1:0] g_i,
  input  logic [plti_pkg::IP:0]   term_i,
  input  logic [plti_pkg::IP:0]   sum_i,
  output logic [plti_pkg::IP-1:0] g_o,
  output logic [plti_pkg::IP:0]   term_o,
  output logic [plti_pkg::IP:0]   sum_o
);

  localparam int IP = plti_pkg::IP;
  localparam logic [31:0] RECIP = 32'(64'hFFFFFFFF / K);
  localparam int KW = $clog2(K + 1);
  localparam logic [KW-1:0] KV = KW'(K);

  logic [2*IP:0]     prod_a;
  logic [IP+31:0]    prod_b;
  logic [IP-1:0]     qe, q;
  logic [IP+KW-1:0]  qk, rem;

  logic [IP-1:0]  a_p_r, a_g_r, b_p_r, b_g_r, c_g_r;
  logic [IP:0]    a_s_r, b_s_r, c_s_r, c_t_r;
  logic [IP+31:0] b_m_r;

  always_comb begin
    prod_a = term_i * g_i;
    prod_b = a_p_r * RECIP;
    qe     = b_m_r[IP+31:32];
    qk     = qe * KV;
    rem    = {{KW{1'b0}}, b_p_r} - qk;
    // reciprocal estimate is at most one low
    q      = qe + IP'(rem >= (IP+KW)'(KV));
  end

  always_ff @(posedge clk) begin
    if (en) begin
      a_p_r <= prod_a[2*IP-1:IP];
      a_g_r <= g_i;
      a_s_r <= sum_i;
      b_m_r <= prod_b;
      b_p_r <= a_p_r;
      b_g_r <= a_g_r;
      b_s_r <= a_s_r;
      c_t_r <= {1'b0, q};
      c_s_r <= b_s_r + {1'b0, q};
      c_g_r <= b_g_r;
    end
  end

  assign g_o    = c_g_r;
  assign term_o = c_t_r;
  assign sum_o  = c_s_r;

endmodule

// File: hw/rtl/pixel_log_transform_and_inverse.sv
// Top level of the pixel log transform and inverse block.
// Depends on plti_pkg and the cells plti_norm_cell, plti_sqr_cell, plti_div_cell, plti_term_cell.
//
// Usage:
//   One pixel (signed Q.FRAC_BITS) enters per transaction on in_valid/in_stall and one
//   result with a status code leaves per transaction on out_valid/out_stall, in order.
//   Forward mode gives norm*log10(x+1) with negative pixels clamped to zero; inverse mode
//   gives 10^(x/norm)-1. A zero norm gives a zero result with the invalid status, and a
//   result past the positive limit saturates with the saturated status.
//   Configuration: cfg_wr_en with cfg_index (0 mode, 1 norm) and cfg_wdata; write only
//   while no transaction is in flight.
//   Throughput is one pixel per cycle while no held result is stalled at the output.
//   The depth is set by the inverse chain: 36 division cells, the log2(10) multiply, and
//   16 exp-series cells of three stages each. The forward chain (normalizer and 30
//   squaring cells) is shorter and its result rides a delay line to line up.
//   Reset clears every valid bit and loads mode 0 and norm 1.0; no pipeline flush needed.
//   When the receiver stalls a held result, the whole chain holds and in_stall rises in
//   the same cycle; it drops as soon as the result is taken.
module pixel_log_transform_and_inverse #(
  parameter int DATA_WIDTH = plti_pkg::DATA_WIDTH_DEF,
  parameter int FRAC_BITS  = plti_pkg::FRAC_BITS_DEF
) (
  input  logic                         clk,
  input  logic                         rst_n,
  input  logic                         in_valid,
  output logic                         in_stall,
  input  logic signed [DATA_WIDTH-1:0] in_pixel_value,
  output logic                         out_valid,
  input  logic                         out_stall,
  output logic signed [DATA_WIDTH-1:0] out_result_value,
  output logic [1:0]                   out_status,
  input  logic                         cfg_wr_en,
  input  logic [0:0]                   cfg_index,
  input  logic [31:0]                  cfg_wdata
);

  localparam int DW    = DATA_WIDTH;
  localparam int FB    = FRAC_BITS;
  localparam int IP    = plti_pkg::IP;
  localparam int QW    = plti_pkg::DIV_STEPS;
  localparam int NT    = plti_pkg::EXP_TERMS;
  localparam int LZW   = $clog2(DW);
  localparam int LW    = LZW + IP;
  localparam int TW    = LW - 1;
  localparam int RW    = 32 + 7;
  localparam int IL    = 1 + QW + 2 + 1 + 1 + 3 * NT + 2;
  localparam int FL    = LZW + IP + 4;
  localparam int DLY   = IL - FL;
  localparam int NLEN  = 1 + 3 * NT;
  localparam int ZW    = 38;

  localparam logic [DW-1:0] ONE_F   = {{(DW-1){1'b0}}, 1'b1} << FB;
  localparam logic [DW-1:0] NEG_ONE = DW'(0) - ONE_F;
  localparam logic [63:0]   POS_MAX64 = (64'd1 << (DW - 1)) - 64'd1;
  localparam logic [DW-1:0] POS_MAX = POS_MAX64[DW-1:0];
  localparam logic [63:0]   ONE_F64 = 64'd1 << FB;
  localparam logic [31:0]   NORM_MASK = (DW >= 32) ? 32'hFFFFFFFF : 32'((64'd1 << DW) - 64'd1);
  localparam logic [IP:0]   ONE_I = {1'b1, {IP{1'b0}}};

  // ---------------------------------------------------------------- configuration
  logic        mode_r;
  logic [31:0] norm_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      mode_r <= 1'b0;
      norm_r <= 32'd65536;
    end else if (cfg_wr_en) begin
      case (cfg_index)
        plti_pkg::CFG_INVERSE_MODE: mode_r <= cfg_wdata[0];
        plti_pkg::CFG_NORM_FACTOR:  norm_r <= cfg_wdata & NORM_MASK;
        default: ;
      endcase
    end
  end

  // ---------------------------------------------------------------- flow control
  // One advance for the whole chain; hold everything while a result waits.
  logic          adv;
  logic [IL:0]   vld_r;
  logic          out_valid_r;

  assign adv      = !out_valid_r || !out_stall;
  assign in_stall = !adv;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vld_r       <= '0;
      out_valid_r <= 1'b0;
    end else if (adv) begin
      vld_r       <= {vld_r[IL-1:0], in_valid};
      out_valid_r <= vld_r[IL];
    end
  end

  // ---------------------------------------------------------------- input stage
  logic [DW-1:0] pix_r;
  logic          neg0;

  always_ff @(posedge clk) begin
    if (adv) pix_r <= in_pixel_value;
  end

  assign neg0 = pix_r[DW-1];

  // ---------------------------------------------------------------- forward chain
  // Normalize x+1 so the leading one sits at the top, then square out the log2 bits.
  logic [DW-1:0]  nw   [LZW+1];
  logic [LZW-1:0] ncnt [LZW+1];

  assign nw[0]   = (neg0 ? '0 : pix_r) + ONE_F;
  assign ncnt[0] = '0;

  for (genvar i = 0; i < LZW; i++) begin : g_norm
    plti_norm_cell #(.DW(DW), .CW(LZW), .SH(1 << (LZW - 1 - i))) u_norm (
      .clk   (clk),
      .en    (adv),
      .w_i   (nw[i]),
      .cnt_i (ncnt[i]),
      .w_o   (nw[i+1]),
      .cnt_o (ncnt[i+1])
    );
  end

  logic [DW+IP:0] nwide;
  logic [LZW-1:0] ex;
  logic [LZW-1:0] e_line_r [IP];
  logic [IP:0]    sm  [IP+1];
  logic [IP-1:0]  sfr [IP+1];

  assign nwide  = {nw[LZW], {(IP+1){1'b0}}};
  assign sm[0]  = nwide[DW+IP -: IP+1];
  assign sfr[0] = '0;
  // integer part of log2: leading-one position minus the fraction bits
  assign ex     = LZW'(DW - 1 - FB) - ncnt[LZW];

  always_ff @(posedge clk) begin
    if (adv) begin
      e_line_r[0] <= ex;
      for (int i = 1; i < IP; i++) e_line_r[i] <= e_line_r[i-1];
    end
  end

  for (genvar i = 0; i < IP; i++) begin : g_sqr
    plti_sqr_cell u_sqr (
      .clk  (clk),
      .en   (adv),
      .m_i  (sm[i]),
      .fr_i (sfr[i]),
      .m_o  (sm[i+1]),
      .fr_o (sfr[i+1])
    );
  end

  logic [LW-1:0]    lg;
  logic [46:0]      pl_lo_r;
  logic [LW+10:0]   pl_hi_r;
  logic [LW+28:0]   tsum;
  logic [TW-1:0]    t_r;
  logic [48:0]      pa_r;
  logic [TW+14:0]   pb_r;
  logic [TW+31:0]   ysum;
  logic [63:0]      yw64;
  logic [DW-1:0]    fy_r;
  plti_pkg::status_t fst_r;

  assign lg   = {e_line_r[IP-1], sfr[IP]};
  assign tsum = {pl_hi_r, 18'b0} + (LW+29)'(pl_lo_r);
  assign ysum = {pb_r, 17'b0} + (TW+32)'(pa_r);
  assign yw64 = 64'(ysum[TW+31:IP]);

  always_ff @(posedge clk) begin
    if (adv) begin
      // log10 = log2 * log10(2), split into two partial products
      pl_lo_r <= lg[17:0] * plti_pkg::LOG10_2_I;
      pl_hi_r <= lg[LW-1:18] * plti_pkg::LOG10_2_I;
      t_r     <= tsum[IP +: TW];
      pa_r    <= norm_r * t_r[16:0];
      pb_r    <= norm_r * t_r[TW-1:17];
      if (yw64 > POS_MAX64) begin
        fy_r  <= POS_MAX;
        fst_r <= plti_pkg::ST_SAT;
      end else begin
        fy_r  <= yw64[DW-1:0];
        fst_r <= plti_pkg::ST_OK;
      end
    end
  end

  // Delay the forward result to the inverse chain's depth.
  logic [DW-1:0]     fd_y_r [DLY];
  plti_pkg::status_t fd_s_r [DLY];

  always_ff @(posedge clk) begin
    if (adv) begin
      fd_y_r[0] <= fy_r;
      fd_s_r[0] <= fst_r;
      for (int i = 1; i < DLY; i++) begin
        fd_y_r[i] <= fd_y_r[i-1];
        fd_s_r[i] <= fd_s_r[i-1];
      end
    end
  end

  // ---------------------------------------------------------------- inverse chain
  logic [DW-1:0] ax;
  logic          clamp;
  logic [RW-1:0] r0_r;
  logic [1:0]    side_r [IL];   // {clamp, neg}, stage k+2 at index k

  assign ax    = neg0 ? (DW'(0) - pix_r) : pix_r;
  assign clamp = (64'(ax) >= (64'(norm_r) << plti_pkg::INT_STEPS));

  always_ff @(posedge clk) begin
    if (adv) begin
      r0_r      <= RW'(ax);
      side_r[0] <= {clamp, neg0};
      for (int i = 1; i < IL; i++) side_r[i] <= side_r[i-1];
    end
  end

  logic [RW-1:0] dr [QW+1];
  logic [QW-1:0] dq [QW+1];

  assign dr[0] = r0_r;
  assign dq[0] = '0;

  for (genvar j = 0; j < QW; j++) begin : g_div
    plti_div_cell #(
      .RW       (RW),
      .SHIFT_IN (j >= plti_pkg::INT_STEPS),
      .DSH      ((j < plti_pkg::INT_STEPS) ? (plti_pkg::INT_STEPS - 1 - j) : 0)
    ) u_div (
      .clk    (clk),
      .en     (adv),
      .norm_i (norm_r),
      .r_i    (dr[j]),
      .q_i    (dq[j]),
      .r_o    (dr[j+1]),
      .q_o    (dq[j+1])
    );
  end

  logic [49:0]        pz_lo_r, pz_hi_r;
  logic [67:0]        zsum;
  logic [ZW-1:0]      z_r;
  logic [7:0]         zi;
  logic [IP-1:0]      zf;
  logic               zneg;
  logic signed [9:0]  nn, n_nxt, n_r;
  logic [IP-1:0]      f_nxt, f_r;
  logic [2*IP-1:0]    gprod;
  logic [IP-1:0]      g_r;
  logic signed [9:0]  nl_r [NLEN];

  assign zsum = {pz_hi_r, 18'b0} + 68'(pz_lo_r);
  assign zi   = z_r[ZW-1:IP];
  assign zf   = z_r[IP-1:0];
  assign zneg = side_r[QW+2][0];

  // Split the exponent into floor and a fraction in [0,1).
  always_comb begin
    nn = {2'b00, zi} + 10'(zf != '0);
    if (zneg) begin
      n_nxt = -nn;
      f_nxt = ~zf + 1'b1;
    end else begin
      n_nxt = {2'b00, zi};
      f_nxt = zf;
    end
  end

  assign gprod = f_r * plti_pkg::LN2_I;

  always_ff @(posedge clk) begin
    if (adv) begin
      pz_lo_r <= dq[QW][17:0] * plti_pkg::LOG2_10_I;
      pz_hi_r <= dq[QW][QW-1:18] * plti_pkg::LOG2_10_I;
      z_r     <= zsum[IP +: ZW];
      n_r     <= n_nxt;
      f_r     <= f_nxt;
      g_r     <= gprod[2*IP-1:IP];
      nl_r[0] <= n_r;
      for (int i = 1; i < NLEN; i++) nl_r[i] <= nl_r[i-1];
    end
  end

  logic [IP-1:0] tg [NT+1];
  logic [IP:0]   tt [NT+1];
  logic [IP:0]   ts [NT+1];

  assign tg[0] = g_r;
  assign tt[0] = ONE_I;
  assign ts[0] = ONE_I;

  for (genvar k = 0; k < NT; k++) begin : g_term
    plti_term_cell #(.K(k + 1)) u_term (
      .clk    (clk),
      .en     (adv),
      .g_i    (tg[k]),
      .term_i (tt[k]),
      .sum_i  (ts[k]),
      .g_o    (tg[k+1]),
      .term_o (tt[k+1]),
      .sum_o  (ts[k+1])
    );
  end

  // Scale 2^f by 2^n into the output fraction format.
  logic signed [9:0] sh;
  logic [9:0]        amt;
  logic [63:0]       pw_nxt, pw_r;
  logic              psat_nxt, psat_r;
  logic [DW-1:0]     iy_r;
  plti_pkg::status_t ist_r;

  always_comb begin
    sh       = nl_r[NLEN-1] + 10'(FB) - 10'(IP);
    amt      = 10'(-sh);
    psat_nxt = 1'b0;
    pw_nxt   = '0;
    if (sh > 10'sd31) begin
      psat_nxt = 1'b1;
    end else if (sh >= 10'sd0) begin
      pw_nxt = 64'(ts[NT]) << sh[4:0];
    end else begin
      pw_nxt = 64'(ts[NT]) >> amt;
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      pw_r   <= pw_nxt;
      psat_r <= psat_nxt;
      if (psat_r || (pw_r > (POS_MAX64 + ONE_F64))) begin
        iy_r  <= POS_MAX;
        ist_r <= plti_pkg::ST_SAT;
      end else begin
        iy_r  <= pw_r[DW-1:0] - ONE_F;
        ist_r <= plti_pkg::ST_OK;
      end
    end
  end

  // ---------------------------------------------------------------- output register
  logic [DW-1:0]     res_r, res_nxt;
  plti_pkg::status_t st_r, st_nxt;
  logic              fin_clamp, fin_neg;

  assign fin_clamp = side_r[IL-1][1];
  assign fin_neg   = side_r[IL-1][0];

  always_comb begin
    if (norm_r == '0) begin
      res_nxt = '0;
      st_nxt  = plti_pkg::ST_BAD_NORM;
    end else if (!mode_r) begin
      res_nxt = fd_y_r[DLY-1];
      st_nxt  = fd_s_r[DLY-1];
    end else if (fin_clamp) begin
      // exponent beyond the range: -1.0 for negative input, saturate otherwise
      res_nxt = fin_neg ? NEG_ONE : POS_MAX;
      st_nxt  = fin_neg ? plti_pkg::ST_OK : plti_pkg::ST_SAT;
    end else begin
      res_nxt = iy_r;
      st_nxt  = ist_r;
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      res_r <= res_nxt;
      st_r  <= st_nxt;
    end
  end

  assign out_valid        = out_valid_r;
  assign out_result_value = res_r;
  assign out_status       = st_r;

endmodule

// File: hw/rtl/plti_checker.sv
// Port-level checks for pixel_log_transform_and_inverse, bound to the top level.
// Depends on plti_pkg for the status codes.
module plti_checker #(
  parameter int DATA_WIDTH = plti_pkg::DATA_WIDTH_DEF
) (
  input logic                  clk,
  input logic                  rst_n,
  input logic                  in_stall,
  input logic                  out_valid,
  input logic                  out_stall,
  input logic [DATA_WIDTH-1:0] out_result_value,
  input logic [1:0]            out_status
);

  localparam logic [DATA_WIDTH-1:0] POS_MAX = {1'b0, {(DATA_WIDTH-1){1'b1}}};

  a_hold_valid: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_stall |=> out_valid)
    else $error("result dropped while stalled");

  a_back_press: assert property (@(posedge clk) disable iff (!rst_n)
    in_stall == (out_valid && out_stall))
    else $error("input stall does not follow held output");

  a_sat_value: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && (out_status == plti_pkg::ST_SAT) |-> out_result_value == POS_MAX)
    else $error("saturated status without limit value");

  a_bad_norm: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && (out_status == plti_pkg::ST_BAD_NORM) |-> out_result_value == '0)
    else $error("invalid norm status with nonzero result");

  a_reset: assert property (@(posedge clk) !rst_n |=> !out_valid)
    else $error("output valid after reset");

endmodule

bind pixel_log_transform_and_inverse plti_checker #(.DATA_WIDTH(DATA_WIDTH)) u_plti_checker (
  .clk              (clk),
  .rst_n            (rst_n),
  .in_stall         (in_stall),
  .out_valid        (out_valid),
  .out_stall        (out_stall),
  .out_result_value (out_result_value),
  .out_status       (out_status)
);

// File: tb/testbench.sv
// Self-checking testbench for pixel_log_transform_and_inverse.
// Depends on plti_pkg and the block's RTL. It predicts each result with its own
// fixed-point log/exp model and checks the results in order.
module testbench;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int          DW        = 32;
  localparam int          FB        = 16;
  localparam int          QB        = 30;               // internal fraction bits
  localparam longint      CYC_LIMIT = 600000;
  localparam int          DRAIN     = 120;              // beyond the pipeline latency
  localparam logic [63:0] ONE_Q     = 64'd1 << QB;
  localparam logic [63:0] ONE_PIX   = 64'd1 << FB;
  localparam logic [63:0] POS_LIM   = (64'd1 << (DW - 1)) - 1;
  localparam logic [63:0] LOG10_2_Q = 64'd323228497;
  localparam logic [63:0] LOG2_10_Q = 64'd3566893132;
  localparam logic [63:0] LN2_Q     = 64'd744261118;

  typedef struct packed {
    logic [DW-1:0]     value;
    plti_pkg::status_t status;
  } pixel_result_t;

  logic                 clk = 1'b0;
  logic                 rst_n = 1'b0;
  logic                 in_valid = 1'b0;
  logic                 in_stall;
  logic signed [DW-1:0] in_pixel_value = '0;
  logic                 out_valid;
  logic                 out_stall = 1'b0;
  logic signed [DW-1:0] out_result_value;
  logic [1:0]           out_status;
  logic                 cfg_wr_en = 1'b0;
  plti_pkg::cfg_idx_t   cfg_index = plti_pkg::CFG_INVERSE_MODE;
  logic [31:0]          cfg_wdata = '0;

  // Testbench copy of the configuration registers.
  logic                 exp_mode = 1'b0;
  logic [31:0]          scale = 32'd65536;

  logic [DW-1:0]        pixel_q[$];
  pixel_result_t        pending_results[$];
  bit                   quiet = 1'b0;     // no idling on either side
  bit                   hold_req = 1'b0;  // ask the receiver for one long hold-off
  int                   hold_left = 0;
  int                   send_gap = 0;
  int                   take_gap = 0;
  int                   errors = 0;
  int                   checked = 0;
  int                   saturated_seen = 0;
  int                   bad_norm_seen = 0;
  longint               cycles = 0;

  pixel_log_transform_and_inverse dut (
    .clk, .rst_n, .in_valid, .in_stall, .in_pixel_value, .out_valid, .out_stall,
    .out_result_value, .out_status, .cfg_wr_en, .cfg_index, .cfg_wdata
  );

  always begin
    #6 clk = 1'b1;
    #6 clk = 1'b0;
  end

  // (a * b) >> s, saturating to all ones when the result exceeds 64 bits.
  function automatic logic [63:0] mul_shift(logic [63:0] a, logic [63:0] b, int s);
    logic [127:0] prod;
    prod = ({64'd0, a} * {64'd0, b}) >> s;
    if (prod[127:64] != 0) return '1;
    return prod[63:0];
  endfunction

  // log2 of u (Q.FB, u >= 1.0) in Q.30, by normalizing and repeated squaring.
  function automatic logic [63:0] log2_fixed(logic [63:0] u);
    int          msb;
    logic [63:0] mant;
    logic [63:0] frac;
    msb = 0;
    frac = 0;
    for (int i = 63; i > 0; i--)
      if (u[i] && msb == 0) msb = i;
    if (msb < FB) return 0;
    mant = (msb > QB) ? (u >> (msb - QB)) : (u << (QB - msb));
    for (int i = 1; i <= QB; i++) begin
      mant = (mant * mant) >> QB;
      if (mant >= 2 * ONE_Q) begin
        mant = mant >> 1;
        frac = frac | (ONE_Q >> i);
      end
    end
    return (64'(msb - FB) << QB) + frac;
  endfunction

  // 2^f for f in [0,1), both Q.30, from the exp series with truncated terms.
  function automatic logic [63:0] pow2_frac(logic [63:0] f);
    logic [63:0] g;
    logic [63:0] sum;
    logic [63:0] term;
    g = (f * LN2_Q) >> QB;
    sum = ONE_Q;
    term = ONE_Q;
    for (int k = 1; k <= 16; k++) begin
      term = ((term * g) >> QB) / 64'(k);
      sum = sum + term;
    end
    return sum;
  endfunction

  function automatic pixel_result_t transform_pixel(logic [DW-1:0] pix);
    pixel_result_t res;
    logic [63:0]   mag, quo, rem, frac, z, e, pw, t, y;
    logic [DW-1:0] pix_neg;
    longint        whole, sh;
    bit            neg;
    neg = pix[DW-1];
    pix_neg = DW'(0) - pix;
    res.value = '0;
    res.status = plti_pkg::ST_OK;
    if (scale == 0) begin
      res.status = plti_pkg::ST_BAD_NORM;
    end else if (!exp_mode) begin
      // Negative pixels clamp to zero before the log.
      t = mul_shift(log2_fixed((neg ? 64'd0 : 64'(pix)) + ONE_PIX), LOG10_2_Q, QB);
      y = mul_shift(64'(scale), t, QB);
      if (y > POS_LIM) begin
        y = POS_LIM;
        res.status = plti_pkg::ST_SAT;
      end
      res.value = y[DW-1:0];
    end else begin
      mag = neg ? 64'(pix_neg) : 64'(pix);
      if (mag >= 64 * 64'(scale)) begin
        // Exponent out of range: saturate up, or settle at exactly -1.0.
        if (neg) begin
          res.value = DW'(-ONE_PIX);
        end else begin
          res.value = POS_LIM[DW-1:0];
          res.status = plti_pkg::ST_SAT;
        end
      end else begin
        quo = mag / scale;
        rem = mag % scale;
        frac = 0;
        for (int i = 0; i < QB; i++) begin
          rem = rem << 1;
          frac = frac << 1;
          if (rem >= scale) begin
            rem = rem - scale;
            frac[0] = 1'b1;
          end
        end
        z = mul_shift((quo << QB) | frac, LOG2_10_Q, QB);
        if (!neg) begin
          whole = longint'(z >> QB);
          frac = z & (ONE_Q - 1);
        end else if ((z & (ONE_Q - 1)) != 0) begin
          whole = -longint'(z >> QB) - 1;
          frac = ONE_Q - (z & (ONE_Q - 1));
        end else begin
          whole = -longint'(z >> QB);
          frac = 0;
        end
        e = pow2_frac(frac);
        sh = whole + FB - QB;
        if (sh > 31) pw = '1;
        else if (sh >= 0) pw = e << sh;
        else if (-sh >= 64) pw = 0;
        else pw = e >> (-sh);
        if (pw > POS_LIM + ONE_PIX) begin
          res.value = POS_LIM[DW-1:0];
          res.status = plti_pkg::ST_SAT;
        end else begin
          res.value = DW'(pw - ONE_PIX);
        end
      end
    end
    return res;
  endfunction

  // Sender: advance through the pixel queue, with random gaps between transactions.
  always @(posedge clk) begin
    if (!rst_n) begin
      in_valid <= 1'b0;
    end else if (!in_valid || !in_stall) begin
      if (send_gap > 0) begin
        send_gap <= send_gap - 1;
        in_valid <= 1'b0;
      end else if (!quiet && $urandom_range(0, 9) == 0) begin
        send_gap <= $urandom_range(0, 11);
        in_valid <= 1'b0;
      end else if (pixel_q.size() > 0) begin
        in_valid <= 1'b1;
        in_pixel_value <= pixel_q.pop_front();
      end else begin
        in_valid <= 1'b0;
      end
    end
  end

  // Predict at acceptance, using the configuration in force.
  always @(posedge clk) begin
    if (rst_n && in_valid && !in_stall)
      pending_results.push_back(transform_pixel(in_pixel_value));
  end

  // Receiver: random stall bursts plus one long hold-off to back up the pipeline.
  always @(posedge clk) begin
    if (!rst_n) begin
      out_stall <= 1'b0;
    end else if (hold_req && hold_left == 0) begin
      hold_req <= 1'b0;
      hold_left <= 400;
      out_stall <= 1'b1;
    end else if (hold_left > 0) begin
      hold_left <= hold_left - 1;
      out_stall <= (hold_left > 1);
    end else if (take_gap > 0) begin
      take_gap <= take_gap - 1;
      out_stall <= (take_gap > 1);
    end else if (!quiet && $urandom_range(0, 9) == 0) begin
      take_gap <= $urandom_range(1, 12);
      out_stall <= 1'b1;
    end else begin
      out_stall <= 1'b0;
    end
  end

  // Check each delivered result against the oldest prediction.
  always @(posedge clk) begin
    pixel_result_t want;
    if (rst_n && out_valid && !out_stall) begin
      if (pending_results.size() == 0) begin
        errors++;
        $display("%0t: unexpected result value=%h status=%0d", $time,
                 out_result_value, out_status);
      end else begin
        want = pending_results.pop_front();
        checked++;
        if (want.status == plti_pkg::ST_SAT) saturated_seen++;
        if (want.status == plti_pkg::ST_BAD_NORM) bad_norm_seen++;
        if (out_result_value !== want.value) begin
          errors++;
          $display("%0t: result_value expected %h actual %h", $time, want.value,
                   out_result_value);
        end
        if (out_status !== want.status) begin
          errors++;
          $display("%0t: status expected %0d actual %0d", $time, want.status, out_status);
        end
      end
    end
  end

  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles > CYC_LIMIT) begin
      $display("timeout after %0d cycles, %0d results outstanding", cycles,
               pending_results.size());
      $display("SCOREBOARD MISMATCH");
      $finish;
    end
  end

  // Wait for the pipeline to drain completely.
  task automatic wait_idle();
    while (pixel_q.size() != 0 || in_valid || pending_results.size() != 0)
      @(posedge clk);
    repeat (DRAIN) @(posedge clk);
  endtask

  task automatic write_reg(plti_pkg::cfg_idx_t idx, logic [31:0] data);
    @(posedge clk);
    cfg_wr_en <= 1'b1;
    cfg_index <= idx;
    cfg_wdata <= data;
    if (idx == plti_pkg::CFG_INVERSE_MODE) exp_mode = data[0];
    else scale = data;
    @(posedge clk);
    cfg_wr_en <= 1'b0;
  endtask

  // Pixel, half the time scaled to the norm so the inverse exponent lands in range.
  function automatic logic [DW-1:0] pick_pixel();
    longint v;
    case ($urandom_range(0, 3))
      0: return $urandom;
      1: return DW'($urandom_range(0, 200000)) - DW'(100000);
      default: begin
        v = (longint'(scale) * (longint'($urandom_range(0, 26000)) - 13000)) / 1024;
        if (v > 64'sh7fffffff) v = 64'sh7fffffff;
        if (v < -64'sh80000000) v = -64'sh80000000;
        return DW'(v);
      end
    endcase
  endfunction

  initial begin
    logic [31:0] scales[8];
    repeat (4) @(posedge clk);
    rst_n <= 1'b1;

    // Forward mode at reset settings: zero, tiny, negative, and the field extremes.
    foreach (scales[i]) scales[i] = 0;
    pixel_q = '{32'h0, 32'h1, 32'hffffffff, 32'h80000000, 32'h7fffffff,
                32'h00010000, 32'h00090000};
    wait_idle();
    // Inverse mode: clamp both ways, saturation, tiny power, both extremes.
    write_reg(plti_pkg::CFG_INVERSE_MODE, 1);
    pixel_q = '{32'h0, 32'h00400000, 32'hffc00000, 32'h7fffffff, 32'h80000000,
                32'h00090000, 32'h000a0000, 32'hffec0000, 32'h1, 32'hffffffff};
    wait_idle();
    // Zero norm is invalid in both modes.
    write_reg(plti_pkg::CFG_NORM_FACTOR, 0);
    pixel_q = '{32'h00010000, 32'hffff0000};
    wait_idle();
    write_reg(plti_pkg::CFG_INVERSE_MODE, 0);
    pixel_q = '{32'h00010000, 32'h7fffffff};
    wait_idle();
    // Largest norm in forward mode overflows for big pixels.
    write_reg(plti_pkg::CFG_NORM_FACTOR, 32'hffffffff);
    pixel_q = '{32'h7fffffff, 32'h00000100, 32'h0};
    wait_idle();

    // Random phases over a spread of settings; the last phase runs with no idling.
    scales = '{32'h1, 32'hffffffff, 32'h00010000, 32'h0, 32'h00000400,
               $urandom, $urandom_range(1, 32'h00100000), 32'h00008000};
    for (int ph = 0; ph < 10; ph++) begin
      write_reg(plti_pkg::CFG_INVERSE_MODE, ph[0]);
      write_reg(plti_pkg::CFG_NORM_FACTOR,
                (ph < 8) ? scales[ph] : $urandom_range(1, 32'h00400000));
      quiet = (ph == 9);
      if (ph == 3) hold_req = 1'b1;
      for (int n = 0; n < 108; n++) pixel_q.push_back(pick_pixel());
      wait_idle();
    end

    $display("checked %0d results over both modes and ten norm settings", checked);
    $display("saturated results %0d, invalid-norm results %0d", saturated_seen,
             bad_norm_seen);
    if (errors == 0 && pending_results.size() == 0) begin
      $display("SCOREBOARD CLEAN");
    end else begin
      $display("SCOREBOARD MISMATCH");
    end
    $finish;
  end
endmodule

// File: pixel_log_transform_and_inverse.f
hw/rtl/plti_pkg.sv
hw/rtl/plti_norm_cell.sv
hw/rtl/plti_sqr_cell.sv
hw/rtl/plti_div_cell.sv
hw/rtl/plti_term_cell.sv
hw/rtl/pixel_log_transform_and_inverse.sv
hw/rtl/plti_checker.sv
tb/testbench.sv
